FILE: rtl/core/vec2_alu_with_normalize_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2D vector unit
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VEC2_ALU_WITH_NORMALIZE_DEFINES_SVH
`define VEC2_ALU_WITH_NORMALIZE_DEFINES_SVH

// Same-cycle implication.
`define V2N_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define V2N_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/v2n_pkg.sv
// ----------------------------------------------------------------------------
// v2n_pkg
// Shared types and constants of the 2D vector unit.
// ----------------------------------------------------------------------------
package v2n_pkg;

	// Fixed-point format and datapath widths.
	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int RAD_W     = 2 * DW;
	localparam int ROOT_W    = 32;
	localparam int SQ_REM_W  = ROOT_W + 3;
	localparam int Q_W       = FRAC_BITS + 1;

	// Operation codes.
	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_MUL   = 3'd2,
		FN_SCALE = 3'd3,
		FN_LEN   = 3'd4,
		FN_NORM  = 3'd5,
		FN_NEG   = 3'd6
	} v2n_func_t;

	// Side data that travels with a beat through the root and divide pipes.
	typedef struct packed {
		v2n_func_t        func;
		logic [DW-1:0]    ax;
		logic [DW-1:0]    ay;
		logic [DW-1:0]    rx;
		logic [DW-1:0]    ry;
		logic             sat;
	} v2n_tag_t;

endpackage

FILE: rtl/core/v2n_sqrt.sv
// ----------------------------------------------------------------------------
// v2n_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v2n_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rad_valid,
	output logic                         rad_stall,
	input  logic [v2n_pkg::RAD_W-1:0]    rad,
	input  v2n_pkg::v2n_tag_t            rad_tag,
	output logic                         root_valid,
	input  logic                         root_stall,
	output logic [v2n_pkg::ROOT_W-1:0]   root,
	output v2n_pkg::v2n_tag_t            root_tag
);
	import v2n_pkg::*;

	localparam int N = ROOT_W;

	logic                  v_s    [0:N];
	logic [SQ_REM_W-1:0]   rem_s  [0:N];
	logic [ROOT_W-1:0]     root_s [0:N];
	logic [RAD_W-1:0]      rad_s  [0:N];
	v2n_tag_t              tag_s  [0:N];
	logic                  rdy    [1:N+1];

	// Stage zero is the input beat itself.
	assign v_s[0]    = rad_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign tag_s[0]  = rad_tag;

	assign rdy[N+1]   = !root_stall;
	assign rad_stall  = !rdy[1];
	assign root_valid = v_s[N];
	assign root       = root_s[N];
	assign root_tag   = tag_s[N];

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [SQ_REM_W-1:0] sh;
		logic [SQ_REM_W-1:0] trial;
		logic                ge;

		// Bring down the next two radicand bits and try the next root bit.
		assign sh    = {rem_s[k-1][SQ_REM_W-3:0], rad_s[k-1][RAD_W-1 -: 2]};
		assign trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, root_s[k-1], 2'b01};
		assign ge    = (sh >= trial);
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k-1]) begin
				rem_s[k]  <= ge ? (sh - trial) : sh;
				root_s[k] <= {root_s[k-1][ROOT_W-2:0], ge};
				rad_s[k]  <= rad_s[k-1] << 2;
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

endmodule

FILE: rtl/core/v2n_div.sv
// ----------------------------------------------------------------------------
// v2n_div
// Pipelined restoring divider for both normalize lanes, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module v2n_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         len_valid,
	output logic                         len_stall,
	input  logic [v2n_pkg::ROOT_W-1:0]   len,
	input  v2n_pkg::v2n_tag_t            len_tag,
	output logic                         quo_valid,
	input  logic                         quo_stall,
	output logic [v2n_pkg::Q_W-1:0]      qx,
	output logic [v2n_pkg::Q_W-1:0]      qy,
	output logic [v2n_pkg::ROOT_W-1:0]   quo_len,
	output v2n_pkg::v2n_tag_t            quo_tag
);
	import v2n_pkg::*;

	localparam int N = Q_W;

	logic                 v_s    [0:N];
	logic [ROOT_W:0]      remx_s [0:N];
	logic [ROOT_W:0]      remy_s [0:N];
	logic [1:0]           nb_s   [0:N];
	logic [Q_W-1:0]       qx_s   [0:N];
	logic [Q_W-1:0]       qy_s   [0:N];
	logic [ROOT_W-1:0]    n_s    [0:N];
	v2n_tag_t             tag_s  [0:N];
	logic                 rdy    [1:N+1];
	logic [DW-1:0]        mx;
	logic [DW-1:0]        my;

	// Magnitudes of the components; each is at most the length.
	assign mx = len_tag.ax[DW-1] ? (~len_tag.ax + 1'b1) : len_tag.ax;
	assign my = len_tag.ay[DW-1] ? (~len_tag.ay + 1'b1) : len_tag.ay;

	// The quotient has no bits above the unit bit, so the partial remainder
	// starts with all but the lowest magnitude bit.
	assign v_s[0]    = len_valid;
	assign remx_s[0] = {2'b00, mx[DW-1:1]};
	assign remy_s[0] = {2'b00, my[DW-1:1]};
	assign nb_s[0]   = {my[0], mx[0]};
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign n_s[0]    = len;
	assign tag_s[0]  = len_tag;

	assign rdy[N+1]  = !quo_stall;
	assign len_stall = !rdy[1];
	assign quo_valid = v_s[N];
	assign qx        = qx_s[N];
	assign qy        = qy_s[N];
	assign quo_len   = n_s[N];
	assign quo_tag   = tag_s[N];

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [ROOT_W:0] shx;
		logic [ROOT_W:0] shy;
		logic [ROOT_W:0] dn;
		logic            gex;
		logic            gey;

		// Shift in the next dividend bit and compare against the length.
		assign shx = {remx_s[k-1][ROOT_W-1:0], nb_s[k-1][0]};
		assign shy = {remy_s[k-1][ROOT_W-1:0], nb_s[k-1][1]};
		assign dn  = {1'b0, n_s[k-1]};
		assign gex = (shx >= dn);
		assign gey = (shy >= dn);
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k-1]) begin
				remx_s[k] <= gex ? (shx - dn) : shx;
				remy_s[k] <= gey ? (shy - dn) : shy;
				nb_s[k]   <= 2'b00;
				qx_s[k]   <= {qx_s[k-1][Q_W-2:0], gex};
				qy_s[k]   <= {qy_s[k-1][Q_W-2:0], gey};
				n_s[k]    <= n_s[k-1];
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

endmodule

FILE: rtl/core/vec2_alu_with_normalize.sv
// ----------------------------------------------------------------------------
// vec2_alu_with_normalize
// Two-component Q16.16 vector unit: add, subtract, product, scale, length,
// normalize and negate, with saturation.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------
//  item     | item_valid, item_stall | func, ax, ay, bx, by, scale
//  result   | res_valid, res_stall   | rx, ry, saturated
//
// One beat is accepted per cycle when no stall holds the pipeline, and every
// operation takes the same Q16.16 path: two front stages (multiply, round
// and add), one stage per root bit in the square root pipe, one per
// quotient bit in the divider, and the output register.
// Reset clears only the valid bits; empty stages fill up under a stall.
// ----------------------------------------------------------------------------
`include "vec2_alu_with_normalize_defines.svh"

module vec2_alu_with_normalize (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [2:0]                func,
	input  logic signed [31:0]        ax,
	input  logic signed [31:0]        ay,
	input  logic signed [31:0]        bx,
	input  logic signed [31:0]        by,
	input  logic signed [31:0]        scale,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [31:0]        rx,
	output logic signed [31:0]        ry,
	output logic                      saturated
);
	import v2n_pkg::*;

	localparam logic signed [RAD_W-1:0] HALF = RAD_W'(1) << (FRAC_BITS - 1);
	localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

	// Clip a 33-bit sum to the signed 32-bit range.
	function automatic logic [DW:0] clip33(input logic [DW:0] v);
		logic ov;
		ov = v[DW] ^ v[DW-1];
		if (!ov) clip33 = {1'b0, v[DW-1:0]};
		else     clip33 = {1'b1, v[DW] ? S_MIN : S_MAX};
	endfunction

	// Clip a 64-bit value to the signed 32-bit range.
	function automatic logic [DW:0] clip64(input logic [RAD_W-1:0] v);
		logic ov;
		ov = !((&v[RAD_W-1:DW-1]) || (~|v[RAD_W-1:DW-1]));
		if (!ov) clip64 = {1'b0, v[DW-1:0]};
		else     clip64 = {1'b1, v[RAD_W-1] ? S_MIN : S_MAX};
	endfunction

	v2n_func_t                 fn;
	logic signed [31:0]        mbx;
	logic signed [31:0]        mby;
	logic signed [RAD_W-1:0]   pxc;
	logic signed [RAD_W-1:0]   pyc;
	logic [DW:0]               exc;
	logic [DW:0]               eyc;
	logic                      rdy_s1;
	logic                      rdy_s2;
	logic                      rdy_out;

	logic                      v_s1;
	v2n_func_t                 func_s1;
	logic [DW-1:0]             ax_s1;
	logic [DW-1:0]             ay_s1;
	logic signed [RAD_W-1:0]   px_s1;
	logic signed [RAD_W-1:0]   py_s1;
	logic [DW:0]               ex_s1;
	logic [DW:0]               ey_s1;

	logic signed [RAD_W-1:0]   rpx;
	logic signed [RAD_W-1:0]   rpy;
	logic [DW:0]               cx;
	logic [DW:0]               cy;
	v2n_tag_t                  tag_c;

	logic                      v_s2;
	logic [RAD_W-1:0]          rad_s2;
	v2n_tag_t                  tag_s2;

	logic                      sq_stall;
	logic                      rt_valid;
	logic                      rt_stall;
	logic [ROOT_W-1:0]         rt;
	v2n_tag_t                  rt_tag;
	logic                      qo_valid;
	logic [Q_W-1:0]            qx;
	logic [Q_W-1:0]            qy;
	logic [ROOT_W-1:0]         qo_len;
	v2n_tag_t                  qo_tag;
	logic                      out_load;
	logic [DW-1:0]             qx32;
	logic [DW-1:0]             qy32;
	logic [DW-1:0]             ox;
	logic [DW-1:0]             oy;
	logic                      osat;

	logic                      res_valid_q;
	logic [DW-1:0]             rx_q;
	logic [DW-1:0]             ry_q;
	logic                      sat_q;

	// Ready chain: a stage takes a beat when it is empty or moving on.
	assign rdy_out    = !res_valid_q || !res_stall;
	assign rdy_s2     = !v_s2 || !sq_stall;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	// Stage 1: operand select, both multipliers and the exact sums.
	assign fn = v2n_func_t'(func);

	always_comb begin
		case (fn)
			FN_MUL: begin
				mbx = bx;
				mby = by;
			end
			FN_SCALE: begin
				mbx = scale;
				mby = scale;
			end
			default: begin
				mbx = ax;
				mby = ay;
			end
		endcase
		case (fn)
			FN_ADD: begin
				exc = 33'(ax) + 33'(bx);
				eyc = 33'(ay) + 33'(by);
			end
			FN_SUB: begin
				exc = 33'(ax) - 33'(bx);
				eyc = 33'(ay) - 33'(by);
			end
			FN_NEG: begin
				exc = -33'(ax);
				eyc = -33'(ay);
			end
			default: begin
				exc = '0;
				eyc = '0;
			end
		endcase
	end

	assign pxc = ax * mbx;
	assign pyc = ay * mby;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			func_s1 <= fn;
			ax_s1   <= ax;
			ay_s1   <= ay;
			px_s1   <= pxc;
			py_s1   <= pyc;
			ex_s1   <= exc;
			ey_s1   <= eyc;
		end
	end

	// Stage 2: product rounding, saturation and the sum of squares.
	assign rpx = (px_s1 + HALF) >>> FRAC_BITS;
	assign rpy = (py_s1 + HALF) >>> FRAC_BITS;

	always_comb begin
		tag_c.func = func_s1;
		tag_c.ax   = ax_s1;
		tag_c.ay   = ay_s1;
		cx = '0;
		cy = '0;
		case (func_s1)
			FN_ADD, FN_SUB, FN_NEG: begin
				cx = clip33(ex_s1);
				cy = clip33(ey_s1);
			end
			FN_MUL, FN_SCALE: begin
				cx = clip64(rpx);
				cy = clip64(rpy);
			end
			default: begin
				cx = '0;
				cy = '0;
			end
		endcase
		tag_c.rx  = cx[DW-1:0];
		tag_c.ry  = cy[DW-1:0];
		tag_c.sat = cx[DW] | cy[DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			rad_s2 <= $unsigned(px_s1) + $unsigned(py_s1);
			tag_s2 <= tag_c;
		end
	end

	// Length of A, then the two normalize quotients.
	v2n_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.rad_valid  (v_s2),
		.rad_stall  (sq_stall),
		.rad        (rad_s2),
		.rad_tag    (tag_s2),
		.root_valid (rt_valid),
		.root_stall (rt_stall),
		.root       (rt),
		.root_tag   (rt_tag)
	);

	v2n_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.len_valid  (rt_valid),
		.len_stall  (rt_stall),
		.len        (rt),
		.len_tag    (rt_tag),
		.quo_valid  (qo_valid),
		.quo_stall  (!rdy_out),
		.qx         (qx),
		.qy         (qy),
		.quo_len    (qo_len),
		.quo_tag    (qo_tag)
	);

	// Output stage: pick the final components for the operation.
	assign out_load = qo_valid && rdy_out;
	assign qx32     = DW'(qx);
	assign qy32     = DW'(qy);

	always_comb begin
		case (qo_tag.func)
			FN_LEN: begin
				ox   = qo_len[ROOT_W-1] ? S_MAX : DW'(qo_len);
				oy   = '0;
				osat = qo_len[ROOT_W-1];
			end
			FN_NORM: begin
				if (qo_tag.ax == '0 && qo_tag.ay == '0) begin
					ox = qo_tag.ax;
					oy = qo_tag.ay;
				end else begin
					ox = qo_tag.ax[DW-1] ? (~qx32 + 1'b1) : qx32;
					oy = qo_tag.ay[DW-1] ? (~qy32 + 1'b1) : qy32;
				end
				osat = 1'b0;
			end
			default: begin
				ox   = qo_tag.rx;
				oy   = qo_tag.ry;
				osat = qo_tag.sat;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rdy_out) begin
			res_valid_q <= qo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rx_q  <= ox;
			ry_q  <= oy;
			sat_q <= osat;
		end
	end

	assign res_valid = res_valid_q;
	assign rx        = rx_q;
	assign ry        = ry_q;
	assign saturated = sat_q;

	// Checks on the pipeline and on the operation results.
	`V2N_ASSERT_IMP(a_empty_front_takes, !v_s1, !item_stall, "front stage empty but stalled")
	`V2N_ASSERT_NXT(a_norm_no_sat, out_load && qo_tag.func == FN_NORM, !saturated, "normalize saturated")
	`V2N_ASSERT_NXT(a_len_ry_zero, out_load && qo_tag.func == FN_LEN, ry == '0, "length ry not zero")
	`V2N_ASSERT_NXT(a_out_loads, out_load, res_valid, "loaded result not shown")

endmodule

FILE: tb/tb_vec2_alu_with_normalize.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vec2_alu_with_normalize
// Drives random and corner-case vector operations into the 2D vector unit,
// predicts each result in Q16.16 and compares every returned beat in order.
// ----------------------------------------------------------------------------
module tb_vec2_alu_with_normalize;
	import v2n_pkg::*;

	// Holds predicted vector results and checks returned beats against them.
	class vec_result_board;
		typedef struct {
			logic [31:0] rx;
			logic [31:0] ry;
			logic        sat;
		} vec_res_t;

		vec_res_t pending[$];
		int       mismatches;

		// Clip a wide value to the signed 32-bit range.
		function automatic logic signed [31:0] clip(logic signed [66:0] v, ref bit hit);
			if (v > 67'sd2147483647) begin
				hit = 1;
				return 32'sh7fffffff;
			end
			if (v < -67'sd2147483648) begin
				hit = 1;
				return 32'sh80000000;
			end
			return v[31:0];
		endfunction

		// Fixed-point product, rounded half up, then clipped.
		function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
				logic signed [31:0] b, ref bit hit);
			logic signed [66:0] p;
			p = 67'(a) * 67'(b) + (67'sd1 <<< (FRAC_BITS - 1));
			return clip(p >>> FRAC_BITS, hit);
		endfunction

		// Floor square root of a 64-bit value, one bit at a time.
		function automatic logic [31:0] floor_root(logic [63:0] s);
			logic [31:0] r;
			r = 0;
			for (int i = 31; i >= 0; i--) begin
				logic [31:0] t;
				t = r | (32'd1 << i);
				if (64'(t) * 64'(t) <= s)
					r = t;
			end
			return r;
		endfunction

		function automatic logic [31:0] vec_len(logic signed [31:0] x, logic signed [31:0] y);
			logic [32:0] mx, my;
			mx = x < 0 ? -33'(x) : 33'(x);
			my = y < 0 ? -33'(y) : 33'(y);
			return floor_root(64'(mx) * 64'(mx) + 64'(my) * 64'(my));
		endfunction

		// Quotient truncated toward zero of (a << FRAC_BITS) / n.
		function automatic logic [31:0] norm_part(logic signed [31:0] a, logic [31:0] n);
			logic [63:0] m, q;
			m = a < 0 ? -64'(signed'(a)) : 64'(a);
			q = (m << FRAC_BITS) / 64'(n);
			return a < 0 ? -q[31:0] : q[31:0];
		endfunction

		// Note an accepted input beat and queue its expected result.
		function void note_input(logic [2:0] fn, logic signed [31:0] ax,
				logic signed [31:0] ay, logic signed [31:0] bx, logic signed [31:0] by,
				logic signed [31:0] sc);
			vec_res_t e;
			bit       hit;
			logic [31:0] n;
			hit = 0;
			e.rx = 0;
			e.ry = 0;
			case (fn)
				FN_ADD: begin
					e.rx = clip(67'(ax) + 67'(bx), hit);
					e.ry = clip(67'(ay) + 67'(by), hit);
				end
				FN_SUB: begin
					e.rx = clip(67'(ax) - 67'(bx), hit);
					e.ry = clip(67'(ay) - 67'(by), hit);
				end
				FN_MUL: begin
					e.rx = fx_mul(ax, bx, hit);
					e.ry = fx_mul(ay, by, hit);
				end
				FN_SCALE: begin
					e.rx = fx_mul(ax, sc, hit);
					e.ry = fx_mul(ay, sc, hit);
				end
				FN_LEN: begin
					n = vec_len(ax, ay);
					if (n[31]) begin
						hit = 1;
						n = 32'h7fffffff;
					end
					e.rx = n;
				end
				FN_NORM: begin
					if (ax != 0 || ay != 0) begin
						n = vec_len(ax, ay);
						e.rx = norm_part(ax, n);
						e.ry = norm_part(ay, n);
					end
				end
				FN_NEG: begin
					e.rx = clip(-67'(ax), hit);
					e.ry = clip(-67'(ay), hit);
				end
				default: ;
			endcase
			e.sat = hit;
			pending.push_back(e);
		endfunction

		// Compare a returned beat with the oldest prediction.
		function void check_result(logic [31:0] rx, logic [31:0] ry, logic sat);
			vec_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat rx=%h ry=%h sat=%b", rx, ry, sat);
				return;
			end
			e = pending.pop_front();
			if (rx !== e.rx || ry !== e.ry || sat !== e.sat) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected rx=%h ry=%h sat=%b, got rx=%h ry=%h sat=%b",
						e.rx, e.ry, e.sat, rx, ry, sat);
			end
		endfunction
	endclass

	localparam int LATENCY = 3 + ROOT_W + FRAC_BITS + 1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [2:0] func;
	logic signed [31:0] ax, ay, bx, by, scale;
	logic res_valid;
	logic res_stall;
	logic signed [31:0] rx, ry;
	logic saturated;
	logic stall_mode;

	vec_result_board board;

	vec2_alu_with_normalize uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func      (func),
		.ax        (ax),
		.ay        (ay),
		.bx        (bx),
		.by        (by),
		.scale     (scale),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.rx        (rx),
		.ry        (ry),
		.saturated (saturated)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Check result beats and note accepted input beats at each edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(rx, ry, saturated);
		if (arst_n && item_valid && !item_stall)
			board.note_input(func, ax, ay, bx, by, scale);
	end

	// Receiver stall pattern: long stall-free stretches alternate with heavy stalling.
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_mode <= 1'b0;
			res_stall  <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= ~stall_mode;
			res_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
		end
	end

	// Pick an edge value or a random word for one operand.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3: return 32'h00010000;
			4: return 32'hffff0000;
			5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	// Present one beat and hold it until accepted.
	task automatic send_beat(logic [2:0] fn, logic [31:0] a0, logic [31:0] a1,
			logic [31:0] b0, logic [31:0] b1, logic [31:0] sc);
		item_valid <= 1'b1;
		func <= fn;
		ax <= a0;
		ay <= a1;
		bx <= b0;
		by <= b1;
		scale <= sc;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		item_valid <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	initial begin
		int burst;
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = FN_ADD;
		ax = 0;
		ay = 0;
		bx = 0;
		by = 0;
		scale = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: every operation, overflow, zero-vector normalize, unused code.
		send_beat(FN_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff, 0);
		send_beat(FN_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 0);
		send_beat(FN_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
		send_beat(FN_MUL, 32'h00008000, 32'hffff8000, 32'h00000001, 32'h00000001, 0);
		send_beat(FN_SCALE, 32'h00020000, 32'hfffe0000, 0, 0, 32'h00018000);
		send_beat(FN_SCALE, 32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000);
		send_beat(FN_LEN, 32'h80000000, 32'h80000000, 0, 0, 0);
		send_beat(FN_LEN, 32'h00030000, 32'hfffc0000, 0, 0, 0);
		send_beat(FN_LEN, 0, 0, 0, 0, 0);
		send_beat(FN_NORM, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_beat(FN_NORM, 32'h80000000, 32'h80000000, 0, 0, 0);
		send_beat(FN_NORM, 32'h00000001, 0, 0, 0, 0);
		send_beat(FN_NORM, 32'h7fffffff, 32'hfffffffd, 0, 0, 0);
		send_beat(FN_NEG, 32'h80000000, 32'h7fffffff, 0, 0, 0);
		send_beat(FN_NEG, 0, 32'h00010000, 0, 0, 0);
		send_beat(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

		// Random bursts with random gaps.
		for (int sent = 0; sent < 1400; ) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				send_beat(3'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word(),
					pick_word(), pick_word());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 8));
		end
		item_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10)
			@(posedge clk);

		if (board.mismatches == 0)
			$display("tb_vec2_alu_with_normalize: clean");
		else
			$display("tb_vec2_alu_with_normalize: errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("tb_vec2_alu_with_normalize: errors");
		$finish;
	end
endmodule
